// ----- rtl/core/svm_pkg.sv -----
package svm_pkg;

	localparam int MAX_LEDS = 64;
	localparam int IDX_W    = $clog2(MAX_LEDS);
	localparam int LEN_W    = IDX_W + 1;
	localparam int CFG_W    = 7;
	localparam int NUM_W    = 8 + IDX_W;

	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LEDS);
	localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(19);
	localparam logic [LEN_W-1:0] SPLIT_LEN = LEN_W'(10);

	localparam logic [CFG_W-1:0] BAT_HIGH = CFG_W'(75);
	localparam logic [CFG_W-1:0] BAT_MID  = CFG_W'(25);

	localparam logic [3:0] HOLD_RELOAD  = 4'd6;
	localparam logic [3:0] HOLD_EXPIRED = 4'hF;

	// x / 3 as (x * 683) >> 11, exact for x below 512
	localparam int DIV3_RECIP = 683;
	localparam int DIV3_SHIFT = 11;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_LEVEL = 1'b1;

	typedef enum logic [1:0] {
		BAT_OFF,
		BAT_RED,
		BAT_AMBER,
		BAT_GREEN
	} bat_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] barlen;
		logic [IDX_W-1:0] start_l;
		logic [IDX_W-1:0] start_r;
		logic [IDX_W-1:0] status;
		logic             left_en;
		logic [7:0]       br;
		logic [7:0]       g0;
		logic [7:0]       step;
		logic [7:0]       sl;
		logic [7:0]       sr;
		logic [7:0]       pk_l;
		logic [7:0]       pk_r;
		logic             comet;
		bat_t             bat;
	} job_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic             last;
	} pix_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [7:0]       den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [7:0] div3(input logic [8:0] x);
		logic [20:0] p;
		p = {12'b0, x} * 21'(DIV3_RECIP);
		return p[DIV3_SHIFT+7:DIV3_SHIFT];
	endfunction

endpackage

// ----- rtl/core/svm_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
module svm_div import svm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       rem_q;
	logic [7:0]       den_q;
	logic [NUM_W-1:0] quo_q;

	logic [8:0] trial;
	logic [8:0] diff;
	logic       ge;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[7:0] : trial[7:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- rtl/core/svm_front.sv -----
module svm_front import svm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       level_left,
	input  logic [7:0]       level_right,
	input  logic [7:0]       brightness,
	input  logic             comet_mode,
	input  logic [CFG_W-1:0] strip_length,
	input  logic [CFG_W-1:0] battery_level,
	output div_req_t         div_req,
	input  div_rsp_t         div_rsp,
	output logic             job_push,
	output job_t             job_data,
	input  logic             job_full
);

	typedef enum logic [5:0] {
		F_IDLE  = 6'b000001,
		F_PREP  = 6'b000010,
		F_DIV_L = 6'b000100,
		F_DIV_R = 6'b001000,
		F_DIV_S = 6'b010000,
		F_PUSH  = 6'b100000
	} fstate_t;

	fstate_t state_q, state_n;

	logic [7:0]       peak_l_q, peak_r_q;
	logic [3:0]       hold_l_q, hold_r_q;
	logic [11:0]      trk_l, trk_r;

	job_t             job_q;
	logic [7:0]       vl_q, vr_q;
	logic [NUM_W-1:0] num_r_q;

	logic [LEN_W-1:0] len_c, len_m1;
	logic             single_c;
	logic [IDX_W-1:0] barlen_c, start_l_c, start_r_c, status_c;
	logic [IDX_W-1:0] barlen_m1;
	logic [8:0]       sum_c;
	bat_t             bat_c;
	logic [NUM_W-1:0] num_l_c, num_r_c;
	logic             accept;

	function automatic logic [11:0] track(input logic [7:0] pk, input logic [3:0] hold,
			input logic [7:0] lvl);
		logic [7:0] pk_n;
		logic [3:0] hold_n;
		pk_n   = lvl;
		hold_n = HOLD_RELOAD;
		if (pk > lvl) begin
			pk_n = pk;
			if (hold == HOLD_EXPIRED) begin
				pk_n = pk - 1'b1;
			end else begin
				hold_n = hold - 1'b1;
			end
		end
		return {pk_n, hold_n};
	endfunction

	function automatic logic [7:0] sat8(input logic [NUM_W-1:0] q);
		return (q[NUM_W-1:8] != '0) ? 8'hFF : q[7:0];
	endfunction

	// strip layout, channel sum and battery band
	always_comb begin
		if (strip_length < CFG_W'(LEN_MIN)) begin
			len_c = LEN_MIN;
		end else if (strip_length > CFG_W'(LEN_MAX)) begin
			len_c = LEN_MAX;
		end else begin
			len_c = LEN_W'(strip_length);
		end
		len_m1   = len_c - 1'b1;
		single_c = len_c < SPLIT_LEN;
		if (single_c) begin
			barlen_c  = len_c[IDX_W-1:0];
			start_l_c = '0;
			start_r_c = '0;
			status_c  = '0;
		end else begin
			barlen_c  = len_m1[LEN_W-1:1];
			start_l_c = len_c[0] ? barlen_c - 1'b1 : barlen_c;
			start_r_c = barlen_c + 1'b1;
			status_c  = barlen_c;
		end
		sum_c = {1'b0, level_left} + {1'b0, level_right};
		if (battery_level > BAT_HIGH) begin
			bat_c = BAT_GREEN;
		end else if (battery_level > BAT_MID) begin
			bat_c = BAT_AMBER;
		end else if (battery_level != '0) begin
			bat_c = BAT_RED;
		end else begin
			bat_c = BAT_OFF;
		end
	end

	assign accept    = push && (state_q == F_IDLE);
	assign full      = (state_q != F_IDLE);
	assign barlen_m1 = job_q.barlen - 1'b1;
	assign num_l_c   = {{(NUM_W-8){1'b0}}, vl_q} * {{(NUM_W-IDX_W){1'b0}}, job_q.barlen};
	assign num_r_c   = {{(NUM_W-8){1'b0}}, vr_q} * {{(NUM_W-IDX_W){1'b0}}, job_q.barlen};
	assign trk_l     = track(peak_l_q, hold_l_q, job_q.sl);
	assign trk_r     = track(peak_r_q, hold_r_q, job_q.sr);

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = num_r_q;
		div_req.den   = job_q.br;
		state_n       = state_q;
		job_push      = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				// zero brightness: beat taken and dropped
				if (push && brightness != '0) begin
					state_n = F_PREP;
				end
			end
			F_PREP: begin
				div_req.start = 1'b1;
				div_req.num   = num_l_c;
				state_n       = F_DIV_L;
			end
			F_DIV_L: begin
				div_req.start = div_rsp.done;
				if (div_rsp.done) begin
					state_n = F_DIV_R;
				end
			end
			F_DIV_R: begin
				div_req.start = div_rsp.done;
				div_req.num   = {{(NUM_W-8){1'b0}}, job_q.br};
				div_req.den   = {{(8-IDX_W){1'b0}}, barlen_m1};
				if (div_rsp.done) begin
					state_n = F_DIV_S;
				end
			end
			F_DIV_S: begin
				if (div_rsp.done) begin
					state_n = F_PUSH;
				end
			end
			F_PUSH: begin
				job_push = !job_full;
				if (!job_full) begin
					state_n = F_IDLE;
				end
			end
			default: state_n = F_IDLE;
		endcase
	end

	always_comb begin
		job_data      = job_q;
		job_data.pk_l = trk_l[11:4];
		job_data.pk_r = trk_r[11:4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			peak_l_q <= '0;
			peak_r_q <= '0;
			hold_l_q <= '0;
			hold_r_q <= '0;
		end else begin
			state_q <= state_n;
			if (job_push) begin
				{peak_l_q, hold_l_q} <= trk_l;
				{peak_r_q, hold_r_q} <= trk_r;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.len     <= len_c;
			job_q.barlen  <= barlen_c;
			job_q.start_l <= start_l_c;
			job_q.start_r <= start_r_c;
			job_q.status  <= status_c;
			job_q.left_en <= !single_c;
			job_q.br      <= brightness;
			job_q.comet   <= comet_mode;
			job_q.bat     <= bat_c;
			job_q.pk_l    <= '0;
			job_q.pk_r    <= '0;
			// single bar: both channels averaged onto the right bar
			vl_q          <= single_c ? 8'd0 : level_left;
			vr_q          <= single_c ? sum_c[8:1] : level_right;
		end
		if (state_q == F_PREP) begin
			num_r_q  <= num_r_c;
			job_q.g0 <= div3({job_q.br, 1'b0});
		end
		if (state_q == F_DIV_L && div_rsp.done) begin
			job_q.sl <= sat8(div_rsp.quo);
		end
		if (state_q == F_DIV_R && div_rsp.done) begin
			job_q.sr <= sat8(div_rsp.quo);
		end
		if (state_q == F_DIV_S && div_rsp.done) begin
			job_q.step <= (div_rsp.quo == '0) ? 8'd1 : div_rsp.quo[7:0];
		end
	end

endmodule

// ----- rtl/core/svm_jobq.sv -----
// two-entry queue of frame jobs between front and back
module svm_jobq import svm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_data,
	output logic full,
	input  logic rd,
	output job_t rd_data,
	output logic empty
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ----- rtl/core/svm_back.sv -----
// walks the strip one LED per cycle while a job waits and the result queue has room, and fills the result queue
module svm_back import svm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_empty,
	input  job_t job,
	output logic job_pop,
	input  logic pop,
	output logic empty,
	output pix_t head
);

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = OQ_AW + 1;

	typedef enum logic [1:0] {
		KIND_BLACK,
		KIND_BAR,
		KIND_STATUS
	} kind_t;

	logic [IDX_W-1:0] p_q;
	logic             last_c, issue;
	logic             left_ok, right_ok, status_ok;
	logic [IDX_W-1:0] i_l, i_r, i_c;
	logic [7:0]       s_c, pk_c;
	kind_t            kind_c;
	logic [NUM_W-1:0] prod_c;

	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1, i_s1;
	logic             last_s1, comet_s1;
	kind_t            kind_s1;
	logic [7:0]       s_s1, pk_s1, br_s1, g0_s1;
	bat_t             bat_s1;
	logic [NUM_W-1:0] prod_s1;

	logic [7:0]       r_bar, g_bar, sh;
	logic             hit_peak, lit;
	pix_t             pix_c;

	pix_t             oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q, rp_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             rd;

	function automatic logic [7:0] dim(input logic [7:0] c, input logic [7:0] s);
		return (s[7:3] != '0) ? 8'd0 : (c >> s[2:0]);
	endfunction

	// which bar or status pixel, if any, covers LED p
	always_comb begin
		last_c    = ({1'b0, p_q} == job.len - 1'b1);
		i_l       = job.start_l - p_q;
		i_r       = p_q - job.start_r;
		left_ok   = job.left_en && (p_q <= job.start_l) && (i_l < job.barlen);
		right_ok  = (p_q >= job.start_r) && (i_r < job.barlen);
		status_ok = (p_q == job.status) && (job.bat != BAT_OFF);
		i_c       = right_ok ? i_r : i_l;
		s_c       = right_ok ? job.sr : job.sl;
		pk_c      = right_ok ? job.pk_r : job.pk_l;
		if (status_ok) begin
			kind_c = KIND_STATUS;
		end else if (right_ok || left_ok) begin
			kind_c = KIND_BAR;
		end else begin
			kind_c = KIND_BLACK;
		end
		prod_c = {{(NUM_W-IDX_W){1'b0}}, i_c} * {{(NUM_W-8){1'b0}}, job.step};
		issue  = !job_empty && ((cnt_q + OQ_CW'(valid_s1)) < OQ_CW'(OQ_DEPTH));
	end

	assign job_pop = issue && last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				p_q <= last_c ? '0 : p_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1   <= p_q;
			last_s1  <= last_c;
			kind_s1  <= kind_c;
			i_s1     <= i_c;
			s_s1     <= s_c;
			pk_s1    <= pk_c;
			br_s1    <= job.br;
			g0_s1    <= job.g0;
			comet_s1 <= job.comet;
			bat_s1   <= job.bat;
			prod_s1  <= prod_c;
		end
	end

	// gradient: red climbs by step to brightness, green falls by step to zero
	always_comb begin
		r_bar    = (prod_s1 >= {{(NUM_W-8){1'b0}}, br_s1}) ? br_s1 : prod_s1[7:0];
		g_bar    = ({{(NUM_W-8){1'b0}}, g0_s1} > prod_s1) ? g0_s1 - prod_s1[7:0] : 8'd0;
		sh       = s_s1 - {{(8-IDX_W){1'b0}}, i_s1};
		hit_peak = (pk_s1 == {{(8-IDX_W){1'b0}}, i_s1});
		lit      = ({{(8-IDX_W){1'b0}}, i_s1} <= s_s1);

		pix_c.idx   = idx_s1;
		pix_c.last  = last_s1;
		pix_c.red   = '0;
		pix_c.green = '0;
		pix_c.blue  = '0;
		unique case (kind_s1)
			KIND_STATUS: begin
				unique case (bat_s1)
					BAT_GREEN: pix_c.green = br_s1;
					BAT_AMBER: begin
						pix_c.red   = br_s1 >> 1;
						pix_c.green = br_s1 >> 1;
					end
					BAT_RED:   pix_c.red = br_s1;
					BAT_OFF:   ;
				endcase
			end
			KIND_BAR: begin
				priority if (hit_peak) begin
					pix_c.red   = r_bar;
					pix_c.green = g_bar;
					pix_c.blue  = br_s1;
				end else if (lit && comet_s1) begin
					pix_c.red   = dim(r_bar, sh);
					pix_c.green = dim(g_bar, sh);
				end else if (lit) begin
					pix_c.red   = r_bar;
					pix_c.green = g_bar;
				end else begin
					pix_c.red = '0;
				end
			end
			default: ;
		endcase
	end

	// result queue
	assign rd    = pop && (cnt_q != '0);
	assign empty = (cnt_q == '0);
	assign head  = oq_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (valid_s1 && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !valid_s1) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[wp_q] <= pix_c;
		end
	end

endmodule

// ----- rtl/core/stereo_vu_meter_led_frame.sv -----
// Stereo VU meter frame generator with peak hold for an RGB LED strip.
// Input queue: a frame update (two levels, brightness, comet mode) is taken
// on push while full is low. Result queue: one beat per LED, in ascending
// index order, while empty is low; pop takes the oldest. last_pixel marks
// the final LED of a frame. The config port (cfg_we, cfg_index, cfg_data)
// sets strip length and battery level; write it only while the block is idle.
// The front spends most of each frame on three 14-step divisions in one
// shared radix-2 divider (both scaled levels and the gradient step).
// The back then delivers one LED per cycle while the result queue has
// room. Up to two frames wait between front and back, so the front takes
// the next update while the back is still drawing. A beat with zero
// brightness is taken and dropped, and full stays low. A stalled result
// side fills a four-deep result queue and then holds the pixel walk;
// nothing is lost. Reset clears peak markers, hold counters and all
// queues and sets the strip length to 19 with the status pixel off.
module stereo_vu_meter_led_frame import svm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           level_left,
	input  logic [7:0]           level_right,
	input  logic [7:0]           brightness,
	input  logic                 comet_mode,
	output logic                 empty,
	input  logic                 pop,
	output logic [IDX_W-1:0]     pixel_index,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic                 last_pixel,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] strip_length_q;
	logic [CFG_W-1:0] battery_level_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	job_t     job_wr, job_rd;
	logic     job_push, job_full, job_pop, job_empty;
	pix_t     head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_length_q  <= LEN_RESET;
			battery_level_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STRIP_LENGTH:  strip_length_q  <= cfg_data;
				CFG_BATTERY_LEVEL: battery_level_q <= cfg_data;
			endcase
		end
	end

	svm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	svm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.level_left    (level_left),
		.level_right   (level_right),
		.brightness    (brightness),
		.comet_mode    (comet_mode),
		.strip_length  (strip_length_q),
		.battery_level (battery_level_q),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.job_push      (job_push),
		.job_data      (job_wr),
		.job_full      (job_full)
	);

	svm_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_push),
		.wr_data (job_wr),
		.full    (job_full),
		.rd      (job_pop),
		.rd_data (job_rd),
		.empty   (job_empty)
	);

	svm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_rd),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	assign pixel_index = head.idx;
	assign red         = head.red;
	assign green       = head.green;
	assign blue        = head.blue;
	assign last_pixel  = head.last;

endmodule

// ----- rtl/core/svm_checker.sv -----
module svm_checker import svm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic [7:0]       brightness,
	input logic             empty,
	input logic             pop,
	input logic [IDX_W-1:0] pixel_index,
	input logic [7:0]       red,
	input logic [7:0]       green,
	input logic [7:0]       blue,
	input logic             last_pixel
);

	// a shown beat stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel_index) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(last_pixel))
		else $error("result beat changed while stalled");

	// inside a frame LEDs come out one after another
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_pixel) ##1 !empty
			|-> pixel_index == IDX_W'($past(pixel_index) + 1'b1))
		else $error("pixel index skipped or repeated");

	// a new frame starts at LED zero
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last_pixel) ##1 !empty |-> pixel_index == '0)
		else $error("frame does not start at LED zero");

	// a dropped zero-brightness frame leaves the input side free
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && brightness == 8'd0 |=> !full)
		else $error("zero-brightness frame occupied the front");

endmodule

bind stereo_vu_meter_led_frame svm_checker u_svm_checker (.*);
